// ----- hdl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAP_WORD_BITS = 32;
    localparam int BIT_IDX_W     = 5;
    localparam int FRAME_SHIFT   = 12;
    localparam int FRAME_IDX_W   = 20;
    localparam int WIDE_IDX_W    = 21;
    localparam int KB_W          = 22;
    localparam int BYTE_ADDR_W   = 32;
    localparam int FADDR_W       = 29;
    localparam int COUNT_OUT_W   = 18;
    localparam int LOW_MEG_KB    = 1024;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_FREE_WR,
        ST_RESULT
    } state_t;

    typedef enum logic {
        CFG_UPPER_KB = 1'b0,
        CFG_RESV_END = 1'b1
    } cfg_idx_t;

endpackage

// ----- hdl/bitmap_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit page frame allocator; one used bit per frame held in a map RAM.
// ----------------------------------------------------------------------------
// Sequence: an in-range free reads its map word and then clears the bit if set;
//   alloc reads one map word per cycle until the first free bit or the last
//   word; init writes one map word per cycle; an unused request goes straight
//   to the result. The next request is taken once the result is loaded.
// Reset: counts and config clear at once; map RAM contents are not cleared,
//   as with a zero frame total no word can act on a result before init.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top #(
    parameter int FRAME_LIMIT = 131072
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] free_address
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [28:0] frame_address, [46:29] frame_total,
                                   // [64:47] frames_in_use, [71:65] zero
    output logic [0:0]  m_tuser    // [0] found
);

    localparam int MAP_WORDS = (FRAME_LIMIT + bfa_pkg::MAP_WORD_BITS - 1)
                               / bfa_pkg::MAP_WORD_BITS;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int CW        = $clog2(FRAME_LIMIT + 1);
    localparam int IW        = bfa_pkg::WIDE_IDX_W;
    localparam int BW        = bfa_pkg::BIT_IDX_W;
    localparam int WB        = bfa_pkg::MAP_WORD_BITS;

    localparam logic [AW:0]   WORD_END  = (AW + 1)'(MAP_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [IW-1:0] MAX_WIDE  = IW'(FRAME_LIMIT);

    // configuration registers
    logic [bfa_pkg::KB_W-1:0]        kb_reg;
    logic [bfa_pkg::BYTE_ADDR_W-1:0] resv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kb_reg   <= '0;
            resv_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bfa_pkg::cfg_idx_t'(cfg_addr))
                bfa_pkg::CFG_UPPER_KB: kb_reg   <= cfg_wdata[bfa_pkg::KB_W-1:0];
                bfa_pkg::CFG_RESV_END: resv_reg <= cfg_wdata;
                default:               kb_reg   <= kb_reg;
            endcase
        end
    end

    // map RAM
    logic [WB-1:0] map_mem [MAP_WORDS];
    logic          rd_en;
    logic [AW-1:0] rd_idx;
    logic [WB-1:0] rdata_reg;
    logic          wr_en;
    logic [AW-1:0] wr_idx;
    logic [WB-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= map_mem[rd_idx];
        end
    end

    // control and state
    bfa_pkg::state_t         state_reg,  state_next;
    logic [AW:0]             ctr_reg,    ctr_next;
    logic [AW-1:0]           word_reg,   word_next;
    logic                    pend_reg,   pend_next;
    logic [BW-1:0]           bitpos_reg, bitpos_next;
    logic [CW-1:0]           managed_reg, managed_next;
    logic [CW-1:0]           used_reg,   used_next;
    logic [IW-1:0]           total_reg,  total_next;
    logic [IW-1:0]           first_reg,  first_next;
    logic [bfa_pkg::FADDR_W-1:0] res_addr_reg, res_addr_next;
    logic                    res_found_reg, res_found_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [bfa_pkg::FADDR_W-1:0]     out_addr_reg;
    logic                            out_found_reg;
    logic [bfa_pkg::COUNT_OUT_W-1:0] out_total_reg;
    logic [bfa_pkg::COUNT_OUT_W-1:0] out_used_reg;
    logic                            out_load;

    // init sizing from registers
    logic [bfa_pkg::KB_W:0]        kb_sum;
    logic [bfa_pkg::BYTE_ADDR_W:0] resv_sum;
    logic [IW-1:0]                 total_raw;
    logic [IW-1:0]                 total_c;
    logic [IW-1:0]                 first_c;

    assign kb_sum    = {1'b0, kb_reg} + (bfa_pkg::KB_W + 1)'(bfa_pkg::LOW_MEG_KB);
    assign resv_sum  = {1'b0, resv_reg}
                       + (bfa_pkg::BYTE_ADDR_W + 1)'((1 << bfa_pkg::FRAME_SHIFT) - 1);
    assign total_raw = kb_sum[bfa_pkg::KB_W:2];
    assign total_c   = (total_raw > MAX_WIDE) ? MAX_WIDE : total_raw;
    assign first_c   = resv_sum[bfa_pkg::BYTE_ADDR_W:bfa_pkg::FRAME_SHIFT];

    // init word: a bit is free when first <= frame < total
    logic [WB-1:0] init_word;

    always_comb
    begin
        logic [IW-1:0] fi;
        fi = '0;
        for (int b = 0; b < WB; b++)
        begin
            fi = IW'({ctr_reg[AW-1:0], BW'(b)});
            init_word[b] = !((fi >= first_reg) && (fi < total_reg));
        end
    end

    // lowest free bit of the word under inspection
    logic [WB-1:0] free_bits;
    logic [BW-1:0] lo_bit;
    logic [IW-1:0] hit_frame;
    logic [bfa_pkg::FRAME_IDX_W-1:0] hit_idx;

    assign free_bits = ~rdata_reg;

    always_comb
    begin
        lo_bit = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                lo_bit = BW'(b);
            end
        end
    end

    assign hit_frame = IW'({word_reg, lo_bit});
    assign hit_idx   = bfa_pkg::FRAME_IDX_W'({word_reg, lo_bit});

    // free request decode
    logic [bfa_pkg::FRAME_IDX_W-1:0] req_frame;
    logic                            req_in_range;

    assign req_frame    = s_tdata[bfa_pkg::BYTE_ADDR_W-1:bfa_pkg::FRAME_SHIFT];
    assign req_in_range = IW'(req_frame) < IW'(managed_reg);

    assign s_tready = (state_reg == bfa_pkg::ST_IDLE);
    assign out_load = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        word_next      = word_reg;
        pend_next      = 1'b0;
        bitpos_next    = bitpos_reg;
        managed_next   = managed_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        first_next     = first_reg;
        res_addr_next  = res_addr_reg;
        res_found_next = res_found_reg;
        m_tvalid_next  = m_tvalid_reg;
        rd_en          = 1'b0;
        rd_idx         = ctr_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_idx         = word_reg;
        wr_data        = rdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            bfa_pkg::ST_IDLE:
            begin
                res_addr_next  = '0;
                res_found_next = 1'b0;
                if (s_tvalid)
                begin
                    case (bfa_pkg::req_t'(s_tuser))
                        bfa_pkg::REQ_ALLOC:
                        begin
                            rd_en      = 1'b1;
                            rd_idx     = '0;
                            word_next  = '0;
                            ctr_next   = (AW + 1)'(1);
                            pend_next  = 1'b1;
                            state_next = bfa_pkg::ST_SCAN;
                        end
                        bfa_pkg::REQ_FREE:
                        begin
                            if (req_in_range)
                            begin
                                rd_en       = 1'b1;
                                rd_idx      = req_frame[BW +: AW];
                                word_next   = req_frame[BW +: AW];
                                bitpos_next = req_frame[BW-1:0];
                                state_next  = bfa_pkg::ST_FREE_WR;
                            end
                            else
                            begin
                                state_next = bfa_pkg::ST_RESULT;
                            end
                        end
                        bfa_pkg::REQ_INIT:
                        begin
                            total_next   = total_c;
                            first_next   = first_c;
                            managed_next = CW'(total_c);
                            used_next    = (first_c < total_c) ? CW'(first_c) : CW'(total_c);
                            ctr_next     = '0;
                            state_next   = bfa_pkg::ST_INIT;
                        end
                        default:
                        begin
                            state_next = bfa_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            bfa_pkg::ST_INIT:
            begin
                wr_en    = 1'b1;
                wr_idx   = ctr_reg[AW-1:0];
                wr_data  = init_word;
                ctr_next = ctr_reg + (AW + 1)'(1);
                if (ctr_reg[AW-1:0] == LAST_WORD)
                begin
                    state_next = bfa_pkg::ST_RESULT;
                end
            end

            bfa_pkg::ST_SCAN:
            begin
                if (ctr_reg != WORD_END)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    ctr_next  = ctr_reg + (AW + 1)'(1);
                    word_next = ctr_reg[AW-1:0];
                end
                if (pend_reg)
                begin
                    if (free_bits != '0)
                    begin
                        if (hit_frame < IW'(managed_reg))
                        begin
                            wr_en          = 1'b1;
                            wr_data        = rdata_reg | (WB'(1) << lo_bit);
                            used_next      = used_reg + CW'(1);
                            res_addr_next  = {hit_idx[bfa_pkg::FADDR_W-bfa_pkg::FRAME_SHIFT-1:0],
                                              bfa_pkg::FRAME_SHIFT'(0)};
                            res_found_next = 1'b1;
                        end
                        rd_en      = 1'b0;
                        pend_next  = 1'b0;
                        state_next = bfa_pkg::ST_RESULT;
                    end
                    else if (word_reg == LAST_WORD)
                    begin
                        rd_en      = 1'b0;
                        pend_next  = 1'b0;
                        state_next = bfa_pkg::ST_RESULT;
                    end
                end
            end

            bfa_pkg::ST_FREE_WR:
            begin
                if (rdata_reg[bitpos_reg])
                begin
                    wr_en     = 1'b1;
                    wr_data   = rdata_reg & ~(WB'(1) << bitpos_reg);
                    used_next = used_reg - CW'(1);
                end
                state_next = bfa_pkg::ST_RESULT;
            end

            bfa_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = bfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::ST_IDLE;
            ctr_reg       <= '0;
            word_reg      <= '0;
            pend_reg      <= 1'b0;
            managed_reg   <= '0;
            used_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            word_reg      <= word_next;
            pend_reg      <= pend_next;
            managed_reg   <= managed_next;
            used_reg      <= used_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bitpos_reg    <= bitpos_next;
        total_reg     <= total_next;
        first_reg     <= first_next;
        res_addr_reg  <= res_addr_next;
        res_found_reg <= res_found_next;
        if ((state_reg == bfa_pkg::ST_RESULT) && out_load)
        begin
            out_addr_reg  <= res_addr_reg;
            out_found_reg <= res_found_reg;
            out_total_reg <= bfa_pkg::COUNT_OUT_W'(managed_reg);
            out_used_reg  <= bfa_pkg::COUNT_OUT_W'(used_reg);
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {7'b0, out_used_reg, out_total_reg, out_addr_reg};
    assign m_tuser[0] = out_found_reg;

    // checks
    a_used_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= managed_reg)
        else $error("used count above frame total");

    a_total_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        IW'(managed_reg) <= MAX_WIDE)
        else $error("frame total above maximum");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfa_pkg::ST_SCAN && wr_en) |=> (used_reg == $past(used_reg) + CW'(1)))
        else $error("allocation did not bump used count");

    a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == bfa_pkg::ST_INIT || state_reg == bfa_pkg::ST_SCAN
                   || state_reg == bfa_pkg::ST_FREE_WR))
        else $error("map write outside init, scan or free");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_frame_allocator_top. A short directed table
// covers reset state, sizing extremes, pool exhaustion, double and
// out-of-range frees and the unused request code. Random phases follow, each
// with its own register setting, mostly alloc/free traffic on frames the
// bench knows to be held. Results are checked field by field against an
// in-bench copy of the frame map, with random stalls on both streams and one
// long sink hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAME_LIMIT = 131072;
    localparam int FRAME_BYTES = 4096;
    localparam int MAP_WORDS   = FRAME_LIMIT / bfa_pkg::MAP_WORD_BITS;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [bfa_pkg::FADDR_W-1:0]     frame_address;
        logic                            found;
        logic [bfa_pkg::COUNT_OUT_W-1:0] frame_total;
        logic [bfa_pkg::COUNT_OUT_W-1:0] frames_in_use;
    } frame_reply_t;

    typedef enum logic {
        ROW_REGS,
        ROW_REQ
    } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        bfa_pkg::req_t op;
        logic [31:0]   arg0;
        logic [31:0]   arg1;
        bit            fixed;
        frame_reply_t  reply;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;

    // frame map shadow
    bit [31:0]                 frame_map [MAP_WORDS];
    int unsigned               managed;
    int unsigned               in_use;
    logic [bfa_pkg::KB_W-1:0]  cfg_upper_kb;
    logic [31:0]               cfg_resv_end;

    frame_reply_t     expected_replies [$];
    logic [31:0]      held_frames [$];
    dir_row_t         dir_rows [$];

    int  errors;
    int  n_alloc_ok;
    int  n_alloc_refused;
    int  n_free;
    int  n_init;
    int  n_nop;
    int  n_checked;
    int  n_settings;
    int  tx_gap_pct;
    int  rx_stall_pct;
    int  rx_hold_left;
    bit  quiet;
    bit  long_hold_req;

    bitmap_frame_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic frame_reply_t serve_request(input bfa_pkg::req_t op,
                                                   input logic [31:0] addr);
        frame_reply_t    r;
        int unsigned     w;
        int unsigned     b;
        int unsigned     f;
        int unsigned     lo;
        bit              done;
        longint unsigned kb_total;
        longint unsigned resv_frames;
        logic [31:0]     byte_addr;
        r = '0;
        case (op)
            bfa_pkg::REQ_ALLOC:
            begin
                done = 1'b0;
                for (w = 0; w < MAP_WORDS && !done; w++)
                begin
                    if (~frame_map[w] != 32'd0)
                    begin
                        for (b = 0; b < bfa_pkg::MAP_WORD_BITS && !done; b++)
                        begin
                            f = w * bfa_pkg::MAP_WORD_BITS + b;
                            if (f >= managed)
                                done = 1'b1;
                            else if (!frame_map[w][b])
                            begin
                                frame_map[w][b] = 1'b1;
                                in_use++;
                                byte_addr = f << bfa_pkg::FRAME_SHIFT;
                                r.frame_address = byte_addr[bfa_pkg::FADDR_W-1:0];
                                r.found = 1'b1;
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            bfa_pkg::REQ_FREE:
            begin
                f = addr >> bfa_pkg::FRAME_SHIFT;
                if (f < managed
                    && frame_map[f / bfa_pkg::MAP_WORD_BITS][f % bfa_pkg::MAP_WORD_BITS])
                begin
                    frame_map[f / bfa_pkg::MAP_WORD_BITS][f % bfa_pkg::MAP_WORD_BITS] = 1'b0;
                    in_use--;
                end
            end
            bfa_pkg::REQ_INIT:
            begin
                kb_total = 64'(cfg_upper_kb);
                kb_total = (kb_total + bfa_pkg::LOW_MEG_KB) / 4;
                if (kb_total > FRAME_LIMIT)
                    kb_total = FRAME_LIMIT;
                resv_frames = 64'(cfg_resv_end);
                resv_frames = (resv_frames + FRAME_BYTES - 1) / FRAME_BYTES;
                for (w = 0; w < MAP_WORDS; w++)
                    frame_map[w] = '1;
                managed = 32'(kb_total);
                lo = (resv_frames < kb_total) ? 32'(resv_frames) : 32'(kb_total);
                for (f = lo; f < managed; f++)
                    frame_map[f / bfa_pkg::MAP_WORD_BITS][f % bfa_pkg::MAP_WORD_BITS] = 1'b0;
                in_use = lo;
            end
            default:
            begin
            end
        endcase
        r.frame_total   = managed[bfa_pkg::COUNT_OUT_W-1:0];
        r.frames_in_use = in_use[bfa_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic void add_req(input bfa_pkg::req_t op, input logic [31:0] addr,
                                    input bit fixed,
                                    input logic [31:0] e_addr, input bit e_found,
                                    input int e_total, input int e_used);
        dir_row_t row;
        row.kind  = ROW_REQ;
        row.op    = op;
        row.arg0  = addr;
        row.arg1  = '0;
        row.fixed = fixed;
        row.reply.frame_address = e_addr[bfa_pkg::FADDR_W-1:0];
        row.reply.found         = e_found;
        row.reply.frame_total   = e_total[bfa_pkg::COUNT_OUT_W-1:0];
        row.reply.frames_in_use = e_used[bfa_pkg::COUNT_OUT_W-1:0];
        dir_rows.push_back(row);
    endfunction

    function automatic void add_regs(input logic [31:0] upper, input logic [31:0] resv);
        dir_row_t row;
        row.kind  = ROW_REGS;
        row.op    = bfa_pkg::REQ_NOP;
        row.arg0  = upper;
        row.arg1  = resv;
        row.fixed = 1'b0;
        row.reply = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_reply();
        frame_reply_t want;
        if (expected_replies.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, got tdata %h tuser %b",
                     $time, m_tdata, m_tuser);
            errors++;
        end
        else
        begin
            want = expected_replies.pop_front();
            n_checked++;
            compare_field("frame_address", 32'(want.frame_address), 32'(m_tdata[28:0]));
            compare_field("found", 32'(want.found), 32'(m_tuser[0]));
            compare_field("frame_total", 32'(want.frame_total), 32'(m_tdata[46:29]));
            compare_field("frames_in_use", 32'(want.frames_in_use), 32'(m_tdata[64:47]));
            compare_field("tdata pad", 32'd0, 32'(m_tdata[71:65]));
        end
    endtask

    // sink side: checks, short random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b1;
        rx_hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_reply();
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                if (rx_hold_left == 0)
                    m_tready <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rx_hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < rx_stall_pct)
            begin
                rx_hold_left = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end
        end
    end

    task automatic send_req(input bfa_pkg::req_t op, input logic [31:0] addr, input bit fixed,
                            input frame_reply_t fixed_reply);
        frame_reply_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = serve_request(op, addr);
        expected_replies.push_back(fixed ? fixed_reply : predicted);
        case (op)
            bfa_pkg::REQ_ALLOC:
            begin
                if (predicted.found)
                begin
                    n_alloc_ok++;
                    held_frames.push_back({3'b000, predicted.frame_address});
                end
                else
                    n_alloc_refused++;
            end
            bfa_pkg::REQ_FREE:
                n_free++;
            bfa_pkg::REQ_INIT:
            begin
                n_init++;
                held_frames.delete();
            end
            default:
                n_nop++;
        endcase
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // registers change only with the block idle
    task automatic program_regs(input logic [bfa_pkg::KB_W-1:0] upper,
                                input logic [31:0] resv);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= bfa_pkg::CFG_UPPER_KB;
        cfg_wdata <= {10'd0, upper};
        @(posedge clk);
        cfg_addr  <= bfa_pkg::CFG_RESV_END;
        cfg_wdata <= resv;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_upper_kb = upper;
        cfg_resv_end = resv;
        n_settings++;
    endtask

    task automatic run_phase(input logic [31:0] upper, input logic [31:0] resv,
                             input int items, input int gap_pct, input int stall_pct,
                             input bit squeeze);
        bfa_pkg::req_t op;
        logic [31:0]   addr;
        int            pick;
        int            idx;
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        program_regs(upper[bfa_pkg::KB_W-1:0], resv);
        send_req(bfa_pkg::REQ_INIT, $urandom(), 1'b0, '0);
        for (int i = 0; i < items; i++)
        begin
            if (squeeze && i == 4)
                long_hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            addr = $urandom();
            if (pick < 45)
                op = bfa_pkg::REQ_ALLOC;
            else if (pick < 72 && held_frames.size() != 0)
            begin
                idx  = $urandom_range(0, held_frames.size() - 1);
                addr = held_frames[idx] | $urandom_range(0, FRAME_BYTES - 1);
                held_frames.delete(idx);
                op   = bfa_pkg::REQ_FREE;
            end
            else if (pick < 84)
                op = bfa_pkg::REQ_FREE;
            else if (pick < 94)
            begin
                // in range, free or used
                addr = ($urandom_range(0, managed - 1) << bfa_pkg::FRAME_SHIFT)
                       | $urandom_range(0, FRAME_BYTES - 1);
                op   = bfa_pkg::REQ_FREE;
            end
            else if (pick < 97)
                op = bfa_pkg::REQ_NOP;
            else
                op = bfa_pkg::REQ_INIT;
            send_req(op, addr, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = bfa_pkg::CFG_UPPER_KB;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = bfa_pkg::REQ_ALLOC;
        quiet     = 1'b0;
        long_hold_req = 1'b0;
        errors = 0;
        n_alloc_ok = 0;
        n_alloc_refused = 0;
        n_free = 0;
        n_init = 0;
        n_nop = 0;
        n_checked = 0;
        n_settings = 0;
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        for (int w = 0; w < MAP_WORDS; w++)
            frame_map[w] = '1;
        managed = 0;
        in_use = 0;
        cfg_upper_kb = '0;
        cfg_resv_end = '0;

        // before any init: out-of-range free and unused code only
        add_req(bfa_pkg::REQ_FREE,  32'h0000_1000, 1'b1, 0, 1'b0, 0, 0);
        add_req(bfa_pkg::REQ_NOP,   32'hFFFF_FFFF, 1'b1, 0, 1'b0, 0, 0);
        add_req(bfa_pkg::REQ_INIT,  32'h0000_0000, 1'b1, 0, 1'b0, 256, 0);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 256, 1);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_1000, 1'b1, 256, 2);
        add_req(bfa_pkg::REQ_FREE,  32'h0000_0FFF, 1'b1, 0, 1'b0, 256, 1);
        add_req(bfa_pkg::REQ_FREE,  32'h0000_0000, 1'b1, 0, 1'b0, 256, 1);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b0, 0, 1'b0, 0, 0);
        add_req(bfa_pkg::REQ_FREE,  32'h0010_0000, 1'b1, 0, 1'b0, 256, 2);
        add_req(bfa_pkg::REQ_FREE,  32'hFFFF_FFFF, 1'b1, 0, 1'b0, 256, 2);
        add_req(bfa_pkg::REQ_NOP,   32'h0000_0000, 1'b1, 0, 1'b0, 256, 2);
        // largest map, whole of it reserved
        add_regs(32'd4193279, 32'hFFFF_FFFF);
        add_req(bfa_pkg::REQ_INIT,  32'hFFFF_FFFF, 1'b1, 0, 1'b0, 131072, 131072);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b1, 0, 1'b0, 131072, 131072);
        add_req(bfa_pkg::REQ_FREE,  32'h1FFF_FFFF, 1'b1, 0, 1'b0, 131072, 131071);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h1FFF_F000, 1'b1, 131072, 131072);
        // reserved end one byte past a frame boundary, a single frame left
        add_regs(32'd0, 32'h000F_E001);
        add_req(bfa_pkg::REQ_INIT,  32'h0000_0000, 1'b1, 0, 1'b0, 256, 255);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h000F_F000, 1'b1, 256, 256);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b1, 0, 1'b0, 256, 256);
        add_req(bfa_pkg::REQ_FREE,  32'h0000_0000, 1'b1, 0, 1'b0, 256, 255);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b0, 0, 1'b0, 0, 0);
        add_regs(32'd4193279, 32'h0000_0000);
        add_req(bfa_pkg::REQ_INIT,  32'h0000_0000, 1'b1, 0, 1'b0, 131072, 0);
        add_req(bfa_pkg::REQ_ALLOC, 32'h0000_0000, 1'b0, 0, 1'b0, 0, 0);
        add_req(bfa_pkg::REQ_NOP,   32'h5A5A_A5A5, 1'b0, 0, 1'b0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REGS)
                program_regs(dir_rows[i].arg0[bfa_pkg::KB_W-1:0], dir_rows[i].arg1);
            else
                send_req(dir_rows[i].op, dir_rows[i].arg0, dir_rows[i].fixed,
                         dir_rows[i].reply);
        end

        run_phase($urandom_range(0, 4193279), $urandom_range(0, 32'h0010_0000), 28, 20, 20, 1'b0);
        run_phase($urandom_range(0, 2047), $urandom_range(0, 32'h000F_0000), 28, 25, 25, 1'b1);
        run_phase($urandom_range(0, 4193279), $urandom_range(0, 32'h1FFF_FFFF), 28, 0, 10, 1'b0);
        quiet = 1'b1;
        run_phase('0, 32'h0000_0000, 28, 0, 0, 1'b0);

        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (MAP_WORDS + 100) @(posedge clk);

        $display("Requests: %0d allocs (%0d refused), %0d frees, %0d inits, %0d unused code",
                 n_alloc_ok + n_alloc_refused, n_alloc_refused, n_free, n_init, n_nop);
        $display("Words checked: %0d across %0d register settings", n_checked, n_settings);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bfa_pkg.sv
hdl/bitmap_frame_allocator_top.sv
tb/tb.sv
